>>> design/fcc_pkg.sv
package fcc_pkg;

    localparam int TEX_WIDTH      = 64;
    localparam int TEX_HEIGHT     = 64;
    localparam int MAX_SCREEN_DIM = 2048;

    localparam int TXW        = $clog2(TEX_WIDTH);
    localparam int TYW        = $clog2(TEX_HEIGHT);
    localparam int WW         = $clog2(MAX_SCREEN_DIM + 1);
    localparam int SLOT_BITS  = 12;
    localparam int STORE_BITS = SLOT_BITS + 1;
    localparam int XW         = 11;
    localparam int NW         = 30;
    localparam int NUMW       = 43;
    localparam int MAGW       = 42;
    localparam int DENW       = WW + XW;

    localparam logic [23:0] DARK_MASK = 24'h7F7F7F;

    typedef enum logic [2:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5,
        REG_WIDTH   = 3'd6,
        REG_HORIZON = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic [WW-1:0]      width;
        logic [10:0]        horizon;
    } t_cfg;

    typedef struct packed {
        logic          pix;
        logic          horiz;
        logic          which;
        logic [11:0]   idx;
        logic [23:0]   color;
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [XW-1:0] d;
    } t_item;

    typedef struct packed {
        logic          valid;
        logic          pix;
        logic          horiz;
        logic          which;
        logic [11:0]   idx;
        logic [23:0]   color;
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic          sx;
        logic          sy;
    } t_tok;

endpackage

>>> design/fcc_front.sv
module fcc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic                  i_which_texture,
    input  logic [11:0]           i_texel_index,
    input  logic [23:0]           i_texel_color,
    input  logic [10:0]           i_pixel_x,
    input  logic [10:0]           i_pixel_y,
    input  logic [10:0]           i_horizon,
    output fcc_pkg::t_item        o_item,
    output logic                  o_item_valid,
    input  logic                  i_pop
);

    fcc_pkg::t_item r_buf [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;
    fcc_pkg::t_item cls;
    logic           push;

    assign o_ready      = (r_count != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item       = r_buf[r_rp];
    assign o_item_valid = (r_count != 2'd0);

    always_comb begin
        cls.pix   = i_mode;
        cls.horiz = (i_pixel_y == i_horizon);
        cls.idx   = i_texel_index;
        cls.color = i_texel_color;
        cls.x     = i_pixel_x;
        cls.y     = i_pixel_y;
        if (i_mode) begin
            cls.which = (i_pixel_y < i_horizon);
        end else begin
            cls.which = i_which_texture;
        end
        if (i_pixel_y < i_horizon) begin
            cls.d = i_horizon - i_pixel_y;
        end else begin
            cls.d = i_pixel_y - i_horizon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0) else $error("pop from empty queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers out of step");
`endif

endmodule

>>> design/fcc_div.sv
module fcc_div (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [fcc_pkg::MAGW-1:0] i_num,
    input  logic [fcc_pkg::DENW-1:0] i_den,
    output logic [fcc_pkg::MAGW-1:0] o_quo,
    output logic                     o_rem_nz
);

    localparam int NB = fcc_pkg::MAGW;
    localparam int DB = fcc_pkg::DENW;

    logic [DB-1:0] r_rem [NB];
    logic [NB-1:0] r_nq  [NB];
    logic [DB-1:0] r_den [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [DB-1:0] rem_in, den_in, rem_next;
        logic [NB-1:0] nq_in;
        logic [DB:0]   t;
        logic          ge;
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_rest
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign den_in = r_den[k-1];
        end
        assign t        = {rem_in, nq_in[NB-1]};
        assign ge       = (t >= {1'b0, den_in});
        assign rem_next = ge ? DB'(t - {1'b0, den_in}) : t[DB-1:0];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= rem_next;
                r_nq[k]  <= {nq_in[NB-2:0], ge};
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo    = r_nq[NB-1];
    assign o_rem_nz = |r_rem[NB-1];

endmodule

>>> design/fcc_back.sv
module fcc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fcc_pkg::t_cfg  i_cfg,
    input  fcc_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [10:0]    o_out_x,
    output logic [10:0]    o_out_y,
    output logic [22:0]    o_color,
    output logic           o_drawn
);

    localparam int NB = fcc_pkg::MAGW;

    logic en;
    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_item_valid;

    // stage 1: products
    fcc_pkg::t_tok                  tok_in, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7, r_t8;
    logic signed [16:0]             dx, dy;
    logic signed [fcc_pkg::NW-1:0]  r_px, r_py, r_qx, r_qy, r_nx, r_ny;
    logic [fcc_pkg::DENW-1:0]       r_den1, r_den2, r_den3, r_den4;
    logic signed [fcc_pkg::NUMW-1:0] r_numx, r_numy;
    logic [fcc_pkg::MAGW-1:0]       r_magx, r_magy;
    logic [fcc_pkg::MAGW-1:0]       quox, quoy;
    logic                           nzx, nzy;
    logic [15:0]                    qx16, qy16, r_qx16, r_qy16, fx, fy;
    logic [31:0]                    prodx, prody, lin;
    logic [fcc_pkg::TXW-1:0]        r_tx;
    logic [fcc_pkg::TYW-1:0]        r_ty;
    logic [fcc_pkg::STORE_BITS-1:0] r_addr;
    logic [23:0]                    r_mem [2**fcc_pkg::STORE_BITS];
    logic [23:0]                    r_rd;
    fcc_pkg::t_tok                  r_dt [NB];

    always_comb begin
        tok_in       = '0;
        tok_in.valid = o_pop;
        tok_in.pix   = i_item.pix;
        tok_in.horiz = i_item.horiz;
        tok_in.which = i_item.which;
        tok_in.idx   = i_item.idx;
        tok_in.color = i_item.color;
        tok_in.x     = i_item.x;
        tok_in.y     = i_item.y;
    end

    assign dx = {i_cfg.dir_x[15], i_cfg.dir_x} - {i_cfg.plane_x[15], i_cfg.plane_x};
    assign dy = {i_cfg.dir_y[15], i_cfg.dir_y} - {i_cfg.plane_y[15], i_cfg.plane_y};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px   <= fcc_pkg::NW'(dx * $signed({1'b0, i_cfg.width}));
            r_py   <= fcc_pkg::NW'(dy * $signed({1'b0, i_cfg.width}));
            r_qx   <= fcc_pkg::NW'(i_cfg.plane_x * $signed({1'b0, i_item.x}));
            r_qy   <= fcc_pkg::NW'(i_cfg.plane_y * $signed({1'b0, i_item.x}));
            r_den1 <= fcc_pkg::DENW'(i_cfg.width * i_item.d);
            r_nx   <= r_px + (r_qx <<< 1);
            r_ny   <= r_py + (r_qy <<< 1);
            r_den2 <= r_den1;
            r_numx <= fcc_pkg::NUMW'(r_nx * $signed({1'b0, i_cfg.horizon})) <<< 2;
            r_numy <= fcc_pkg::NUMW'(r_ny * $signed({1'b0, i_cfg.horizon})) <<< 2;
            r_den3 <= r_den2;
            r_magx <= r_numx[fcc_pkg::NUMW-1] ? fcc_pkg::MAGW'(-r_numx)
                                              : r_numx[fcc_pkg::MAGW-1:0];
            r_magy <= r_numy[fcc_pkg::NUMW-1] ? fcc_pkg::MAGW'(-r_numy)
                                              : r_numy[fcc_pkg::MAGW-1:0];
            r_den4 <= r_den3;
        end
    end

    fcc_div u_div_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r_magx),
        .i_den    (r_den4),
        .o_quo    (quox),
        .o_rem_nz (nzx)
    );

    fcc_div u_div_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r_magy),
        .i_den    (r_den4),
        .o_quo    (quoy),
        .o_rem_nz (nzy)
    );

    // floor correction and wrap to the fractional part
    assign qx16 = r_dt[NB-1].sx ? 16'(-(quox[15:0] + 16'(nzx))) : quox[15:0];
    assign qy16 = r_dt[NB-1].sy ? 16'(-(quoy[15:0] + 16'(nzy))) : quoy[15:0];
    assign fx    = i_cfg.pos_x[15:0] + r_qx16;
    assign fy    = i_cfg.pos_y[15:0] + r_qy16;
    assign prodx = 32'(fx) * 32'(fcc_pkg::TEX_WIDTH);
    assign prody = 32'(fy) * 32'(fcc_pkg::TEX_HEIGHT);
    assign lin   = 32'(r_ty) * 32'(fcc_pkg::TEX_WIDTH) + 32'(r_tx);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx16 <= qx16;
            r_qy16 <= qy16;
            r_tx   <= prodx[16 +: fcc_pkg::TXW];
            r_ty   <= prody[16 +: fcc_pkg::TYW];
            if (r_t6.pix) begin
                r_addr <= {r_t6.which, lin[fcc_pkg::SLOT_BITS-1:0]};
            end else begin
                r_addr <= {r_t6.which, r_t6.idx};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_t7.valid) begin
            if (!r_t7.pix) begin
                r_mem[r_addr] <= r_t7.color;
            end else begin
                r_rd <= r_mem[r_addr];
            end
        end
    end

    // token line alongside the datapath
    fcc_pkg::t_tok t4s;

    always_comb begin
        t4s    = r_t3;
        t4s.sx = r_numx[fcc_pkg::NUMW-1];
        t4s.sy = r_numy[fcc_pkg::NUMW-1];
    end

    for (genvar k = 0; k < NB; k++) begin : g_tok
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dt[k] <= '0;
                end else if (en) begin
                    r_dt[k] <= r_t4;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dt[k] <= '0;
                end else if (en) begin
                    r_dt[k] <= r_dt[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
            r_t5 <= '0;
            r_t6 <= '0;
            r_t7 <= '0;
            r_t8 <= '0;
        end else if (en) begin
            r_t1 <= tok_in;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= t4s;
            r_t5 <= r_dt[NB-1];
            r_t6 <= r_t5;
            r_t7 <= r_t6;
            r_t8 <= r_t7;
        end
    end

    assign o_valid = r_t8.valid && r_t8.pix;
    assign o_out_x = r_t8.x;
    assign o_out_y = r_t8.y;
    assign o_drawn = !r_t8.horiz;
    assign o_color = r_t8.horiz ? 23'd0
                                : 23'((r_rd >> 1) & fcc_pkg::DARK_MASK);

`ifndef SYNTHESIS
    a_horizon_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_drawn) |-> o_color == 23'd0) else $error("horizon beat colored");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_t8) && $stable(r_addr)) else $error("pipeline moved in stall");
    a_pop_only_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_t1.valid) else $error("popped item lost");
`endif

endmodule

>>> design/floor_ceiling_texture_caster.sv
// A beat passes the input queue and the product, sum, numerator, magnitude,
// divider, fraction, texel, address and store read registers. Throughput:
// one beat per cycle while the output is ready, loads and pixels alike; set
// by the 42-stage pipelined restoring divider and the single-port texel store.
// Reset (i_rst_n, synchronous, active low) clears the queue, the pipeline valid
// bits and the registers to their defaults; texel store contents are undefined.
module floor_ceiling_texture_caster (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic        i_which_texture,
    input  logic [11:0] i_texel_index,
    input  logic [23:0] i_texel_color,
    input  logic [10:0] i_pixel_x,
    input  logic [10:0] i_pixel_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_out_x,
    output logic [10:0] o_out_y,
    output logic [22:0] o_color,
    output logic        o_drawn
);

    logic signed [31:0] r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [11:0]        r_width;
    logic [10:0]        r_horizon;
    fcc_pkg::t_reg_idx  idx;
    fcc_pkg::t_cfg      cfg;
    fcc_pkg::t_item     item;
    logic               item_valid, pop;

    assign pready = 1'b1;
    assign idx    = fcc_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 32'sd0;
            r_pos_y   <= 32'sd0;
            r_dir_x   <= 16'sd16384;
            r_dir_y   <= 16'sd0;
            r_plane_x <= 16'sd0;
            r_plane_y <= 16'sd10813;
            r_width   <= 12'd640;
            r_horizon <= 11'd240;
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                fcc_pkg::REG_POS_X:   r_pos_x   <= pwdata;
                fcc_pkg::REG_POS_Y:   r_pos_y   <= pwdata;
                fcc_pkg::REG_DIR_X:   r_dir_x   <= pwdata[15:0];
                fcc_pkg::REG_DIR_Y:   r_dir_y   <= pwdata[15:0];
                fcc_pkg::REG_PLANE_X: r_plane_x <= pwdata[15:0];
                fcc_pkg::REG_PLANE_Y: r_plane_y <= pwdata[15:0];
                fcc_pkg::REG_WIDTH:   r_width   <= pwdata[11:0];
                fcc_pkg::REG_HORIZON: r_horizon <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            fcc_pkg::REG_POS_X:   prdata = r_pos_x;
            fcc_pkg::REG_POS_Y:   prdata = r_pos_y;
            fcc_pkg::REG_DIR_X:   prdata = {{16{r_dir_x[15]}}, r_dir_x};
            fcc_pkg::REG_DIR_Y:   prdata = {{16{r_dir_y[15]}}, r_dir_y};
            fcc_pkg::REG_PLANE_X: prdata = {{16{r_plane_x[15]}}, r_plane_x};
            fcc_pkg::REG_PLANE_Y: prdata = {{16{r_plane_y[15]}}, r_plane_y};
            fcc_pkg::REG_WIDTH:   prdata = {20'd0, r_width};
            fcc_pkg::REG_HORIZON: prdata = {21'd0, r_horizon};
            default:              prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.pos_x   = r_pos_x;
        cfg.pos_y   = r_pos_y;
        cfg.dir_x   = r_dir_x;
        cfg.dir_y   = r_dir_y;
        cfg.plane_x = r_plane_x;
        cfg.plane_y = r_plane_y;
        cfg.horizon = r_horizon;
        if (r_width == 12'd0) begin
            cfg.width = fcc_pkg::WW'(1);
        end else if (32'(r_width) > fcc_pkg::MAX_SCREEN_DIM) begin
            cfg.width = fcc_pkg::WW'(fcc_pkg::MAX_SCREEN_DIM);
        end else begin
            cfg.width = fcc_pkg::WW'(r_width);
        end
    end

    fcc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_which_texture (i_which_texture),
        .i_texel_index   (i_texel_index),
        .i_texel_color   (i_texel_color),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_horizon       (r_horizon),
        .o_item          (item),
        .o_item_valid    (item_valid),
        .i_pop           (pop)
    );

    fcc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_color      (o_color),
        .o_drawn      (o_drawn)
    );

endmodule
